// ===== rtl/core/trc_pkg.sv =====
package trc_pkg;

  // Widths of the query datapath
  localparam int unsigned SIZE_W     = 10;  // table entry, CTUs minus one
  localparam int unsigned PIC_W      = 15;  // picture dimension in samples
  localparam int unsigned CTB_W      = 15;  // picture dimension in CTUs
  localparam int unsigned POS_W      = 14;  // tile top / left
  localparam int unsigned LEN_W      = 15;  // tile width / height
  localparam int unsigned SLOT_W     = 5;   // column or row number
  localparam int unsigned NUM_W      = 6;   // number of columns or rows, 1 to 32
  localparam int unsigned IDX_W      = 10;  // raster tile number
  localparam int unsigned SUM_W      = 23;  // running sum of explicit sizes
  localparam int unsigned DIV_W      = 21;  // dividend and quotient of the divider
  localparam int unsigned DVS_W      = NUM_W;
  localparam int unsigned DCNT_W     = 5;   // divider step counter
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef enum logic [1:0] {
    KIND_COL   = 2'd0,
    KIND_ROW   = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_OVER  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIC_W    = 3'd0,
    REG_PIC_H    = 3'd1,
    REG_CTU_LOG2 = 3'd2,
    REG_UNIFORM  = 3'd3,
    REG_COLS_M1  = 3'd4,
    REG_ROWS_M1  = 3'd5
  } cfg_reg_e;

  // Request to and response from the shared divider
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

  // Clamp a position to the top / left range
  function automatic logic [POS_W-1:0] sat_pos(input logic [SUM_W-1:0] v);
    logic [POS_W-1:0] r;
    r = (v > SUM_W'(POS_MAX)) ? POS_MAX : v[POS_W-1:0];
    return r;
  endfunction

  // Clamp a length to the width / height range
  function automatic logic [LEN_W-1:0] sat_len(input logic [SUM_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = (v > SUM_W'(LEN_MAX)) ? LEN_MAX : v[LEN_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/trc_div.sv =====
module trc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  trc_pkg::div_req_t req_i,
  output trc_pkg::div_rsp_t rsp_o
);
  import trc_pkg::*;

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVS_W:0]    trial;
  logic              ge;

  // One restoring step: shift in the next dividend bit and try the subtract
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = '0;
      quo_d = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
    end else if (run_q) begin
      quo_d = {quo_q[DIV_W-2:0], ge};
      rem_d = DVS_W'(ge ? (trial - {1'b0, dvs_q}) : trial);
      cnt_d = cnt_q + DCNT_W'(1);
      if (cnt_q == DCNT_W'(DIV_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

  a_start_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !run_q)
    else $error("divider started while running");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |=> !rsp_o.done)
    else $error("divider done longer than one cycle");

  a_done_not_running : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |-> !run_q)
    else $error("divider done while still running");

endmodule

// ===== rtl/core/trc_table.sv =====
module trc_table #(
  parameter  int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [trc_pkg::SIZE_W-1:0] wr_data_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  output logic [trc_pkg::SIZE_W-1:0] rd_data_o
);
  import trc_pkg::*;

  logic [SIZE_W-1:0] mem_q [Depth];
  logic [SIZE_W-1:0] rd_data_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/hevc_tile_region_calc_core.sv =====
// Table write requests (kinds 0 and 1) and unknown kinds give no result and leave the core idle.
// A query outside the grid gives its result in the cycle after it is taken.
// Other queries: the index split on the divider, then per axis two passes of the bit-serial
// divider in uniform mode or one table read per column or row in table mode; columns first,
// then rows, and the strobe after the row axis closes.
// busy_o drops in the strobe cycle; reset restores the default picture and grid.
module hevc_tile_region_calc_core #(
  parameter int unsigned MAX_TILE_COLUMNS = 32,
  parameter int unsigned MAX_TILE_ROWS    = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    kind_i,
  input  logic [trc_pkg::SLOT_W-1:0]     table_slot_i,
  input  logic [trc_pkg::SIZE_W-1:0]     size_in_ctus_minus1_i,
  input  logic [trc_pkg::IDX_W-1:0]      tile_index_i,
  output logic                          done_o,
  output logic [trc_pkg::POS_W-1:0]      tile_top_o,
  output logic [trc_pkg::POS_W-1:0]      tile_left_o,
  output logic [trc_pkg::LEN_W-1:0]      tile_width_o,
  output logic [trc_pkg::LEN_W-1:0]      tile_height_o,
  output logic [1:0]                    status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [trc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [trc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import trc_pkg::*;

  localparam int unsigned COL_AW = (MAX_TILE_COLUMNS > 1) ? $clog2(MAX_TILE_COLUMNS) : 1;
  localparam int unsigned ROW_AW = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GRID   = 3'd1;
  localparam logic [2:0] S_AXIS   = 3'd2;
  localparam logic [2:0] S_U_ST0  = 3'd3;
  localparam logic [2:0] S_U_DIV0 = 3'd4;
  localparam logic [2:0] S_U_DIV1 = 3'd5;
  localparam logic [2:0] S_E_RUN  = 3'd6;
  localparam logic [2:0] S_E_LAST = 3'd7;

  // Configuration registers
  logic [PIC_W-1:0]  pic_w_q, pic_h_q;
  logic [2:0]        ctu_log2_q;
  logic              uniform_q;
  logic [SLOT_W-1:0] cols_m1_q, rows_m1_q;

  // Sequencer and datapath registers
  logic [2:0]        state_q, state_d;
  logic              done_q, done_d;
  logic              axis_q, axis_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic              rdv_q, rdv_d;
  logic [SLOT_W-1:0] rd_i_q, rd_i_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SUM_W-1:0]  before_q, before_d;
  logic [CTB_W-1:0]  ctbs_q, ctbs_d;
  logic [CTB_W-1:0]  s0_q, s0_d;
  logic [NUM_W-1:0]  cols_q, cols_d, rows_q, rows_d;
  logic [SLOT_W-1:0] col_q, col_d, row_q, row_d;
  logic              over_x_q, over_x_d;
  logic [POS_W-1:0]  top_q, top_d, left_q, left_d;
  logic [LEN_W-1:0]  width_q, width_d, height_q, height_d;
  logic [1:0]        status_q, status_d;

  // Combinational helpers
  logic [NUM_W-1:0]  cols_cfg, rows_cfg, cols_full, rows_full;
  logic [IDX_W:0]    grid_size;
  logic              out_of_grid;
  logic [2:0]        sh;
  logic [PIC_W-1:0]  full;
  logic [NUM_W-1:0]  n, n_m1;
  logic [SLOT_W-1:0] pos;
  logic              is_last;
  logic [SIZE_W-1:0] rd_data, col_rd_data, row_rd_data;
  logic [SUM_W-1:0]  w_rd;
  logic [CTB_W:0]    ctbs_sum;
  logic [CTB_W-1:0]  s1;
  logic [SUM_W-1:0]  start_u;
  logic              over_e;
  logic              ax_end;
  logic [POS_W-1:0]  ax_start;
  logic [LEN_W-1:0]  ax_len;
  logic              ax_over;
  logic [SLOT_W-1:0] rd_idx;
  logic              accept, col_wr, row_wr;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign accept = start_i && !busy_o;

  // Grid size, limited to the table depth
  assign cols_full = {1'b0, cols_m1_q} + NUM_W'(1);
  assign rows_full = {1'b0, rows_m1_q} + NUM_W'(1);
  assign cols_cfg  = ((NUM_W + 1)'(cols_full) > (NUM_W + 1)'(MAX_TILE_COLUMNS)) ?
                     NUM_W'(MAX_TILE_COLUMNS) : cols_full;
  assign rows_cfg  = ((NUM_W + 1)'(rows_full) > (NUM_W + 1)'(MAX_TILE_ROWS)) ?
                     NUM_W'(MAX_TILE_ROWS) : rows_full;
  assign grid_size   = (IDX_W + 1)'(cols_cfg) * (IDX_W + 1)'(rows_cfg);
  assign out_of_grid = ((IDX_W + 1)'(tile_index_i) >= grid_size);

  // Per-axis selection
  assign sh      = ctu_log2_q;
  assign full    = axis_q ? pic_h_q : pic_w_q;
  assign n       = axis_q ? rows_q : cols_q;
  assign pos     = axis_q ? row_q : col_q;
  assign n_m1    = n - NUM_W'(1);
  assign is_last = ({1'b0, pos} == n_m1);
  assign rd_data = axis_q ? row_rd_data : col_rd_data;
  assign w_rd    = (SUM_W'(rd_data) + SUM_W'(1)) << sh;

  // Picture size in CTUs, rounded up
  assign ctbs_sum = (CTB_W + 1)'(full) + (CTB_W + 1)'((8'd1 << sh) - 8'd1);

  // Uniform split results
  assign s1      = div_rsp.quotient[CTB_W-1:0];
  assign start_u = SUM_W'(s0_q) << sh;

  // Table read address: the running entry while summing, else the tile's own
  assign rd_idx = (state_q == S_E_RUN && {1'b0, cnt_q} < n_m1) ? cnt_q : pos;

  // Table writes, taken in the accepting cycle
  assign col_wr = accept && (kind_i == KIND_COL) &&
                  ((NUM_W + 1)'(table_slot_i) < (NUM_W + 1)'(MAX_TILE_COLUMNS));
  assign row_wr = accept && (kind_i == KIND_ROW) &&
                  ((NUM_W + 1)'(table_slot_i) < (NUM_W + 1)'(MAX_TILE_ROWS));

  trc_table #(
    .Depth (MAX_TILE_COLUMNS)
  ) u_col_table (
    .clk_i     (clk_i),
    .wr_en_i   (col_wr),
    .wr_addr_i (COL_AW'(table_slot_i)),
    .wr_data_i (size_in_ctus_minus1_i),
    .rd_addr_i (COL_AW'(rd_idx)),
    .rd_data_o (col_rd_data)
  );

  trc_table #(
    .Depth (MAX_TILE_ROWS)
  ) u_row_table (
    .clk_i     (clk_i),
    .wr_en_i   (row_wr),
    .wr_addr_i (ROW_AW'(table_slot_i)),
    .wr_data_i (size_in_ctus_minus1_i),
    .rd_addr_i (ROW_AW'(rd_idx)),
    .rd_data_o (row_rd_data)
  );

  trc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Axis result at the end of either split
  assign over_e = (sum_q > SUM_W'(full));

  always_comb begin
    ax_end   = 1'b0;
    ax_start = '0;
    ax_len   = '0;
    ax_over  = 1'b0;
    if (state_q == S_U_DIV1) begin
      ax_end   = div_rsp.done;
      ax_start = sat_pos(start_u);
      ax_len   = is_last ? LEN_W'(SUM_W'(full) - start_u) :
                           sat_len(SUM_W'(s1 - s0_q) << sh);
    end else if (state_q == S_E_LAST) begin
      ax_end   = 1'b1;
      ax_start = sat_pos(before_q);
      ax_over  = over_e;
      if (is_last) begin
        ax_len = over_e ? '0 : LEN_W'(SUM_W'(full) - sum_q);
      end else begin
        ax_len = sat_len(w_rd);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    axis_d   = axis_q;
    cnt_d    = cnt_q;
    rdv_d    = 1'b0;
    rd_i_d   = rd_i_q;
    sum_d    = sum_q;
    before_d = before_q;
    ctbs_d   = ctbs_q;
    s0_d     = s0_q;
    cols_d   = cols_q;
    rows_d   = rows_q;
    col_d    = col_q;
    row_d    = row_q;
    over_x_d = over_x_q;
    top_d    = top_q;
    left_d   = left_q;
    width_d  = width_q;
    height_d = height_q;
    status_d = status_q;
    div_req  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i && kind_i == KIND_QUERY) begin
          cols_d = cols_cfg;
          rows_d = rows_cfg;
          if (out_of_grid) begin
            top_d    = '0;
            left_d   = '0;
            width_d  = '0;
            height_d = '0;
            status_d = STATUS_RANGE;
            done_d   = 1'b1;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(tile_index_i);
            div_req.divisor  = cols_cfg;
            state_d          = S_GRID;
          end
        end
      end
      S_GRID: begin
        if (div_rsp.done) begin
          row_d   = div_rsp.quotient[SLOT_W-1:0];
          col_d   = div_rsp.remainder[SLOT_W-1:0];
          axis_d  = 1'b0;
          state_d = S_AXIS;
        end
      end
      S_AXIS: begin
        ctbs_d   = CTB_W'(ctbs_sum >> sh);
        cnt_d    = '0;
        sum_d    = '0;
        before_d = '0;
        state_d  = uniform_q ? S_U_ST0 : S_E_RUN;
      end
      S_U_ST0: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(pos) * DIV_W'(ctbs_q);
        div_req.divisor  = n;
        state_d          = S_U_DIV0;
      end
      S_U_DIV0: begin
        if (div_rsp.done) begin
          s0_d             = div_rsp.quotient[CTB_W-1:0];
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'({1'b0, pos} + NUM_W'(1)) * DIV_W'(ctbs_q);
          div_req.divisor  = n;
          state_d          = S_U_DIV1;
        end
      end
      S_U_DIV1: begin
        // axis end handled below
      end
      S_E_RUN: begin
        // add the entry that arrived from the previous read
        if (rdv_q) begin
          sum_d = sum_q + w_rd;
          if (rd_i_q < pos) begin
            before_d = before_q + w_rd;
          end
        end
        if ({1'b0, cnt_q} < n_m1) begin
          rdv_d  = 1'b1;
          rd_i_d = cnt_q;
          cnt_d  = cnt_q + SLOT_W'(1);
        end else begin
          state_d = S_E_LAST;
        end
      end
      S_E_LAST: begin
        // axis end handled below
      end
      default: state_d = S_IDLE;
    endcase

    // Close an axis: columns first, then rows and deliver
    if (ax_end) begin
      if (!axis_q) begin
        left_d   = ax_start;
        width_d  = ax_len;
        over_x_d = ax_over;
        axis_d   = 1'b1;
        state_d  = S_AXIS;
      end else begin
        top_d    = ax_start;
        height_d = ax_len;
        status_d = (over_x_q || ax_over) ? STATUS_OVER : STATUS_OK;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
    end
  end

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pic_w_q    <= PIC_W'(3840);
      pic_h_q    <= PIC_W'(1920);
      ctu_log2_q <= 3'd6;
      uniform_q  <= 1'b1;
      cols_m1_q  <= '0;
      rows_m1_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_PIC_W:    pic_w_q    <= cfg_data_i;
        REG_PIC_H:    pic_h_q    <= cfg_data_i;
        REG_CTU_LOG2: ctu_log2_q <= cfg_data_i[2:0];
        REG_UNIFORM:  uniform_q  <= cfg_data_i[0];
        REG_COLS_M1:  cols_m1_q  <= cfg_data_i[SLOT_W-1:0];
        REG_ROWS_M1:  rows_m1_q  <= cfg_data_i[SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      axis_q  <= 1'b0;
      rdv_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      axis_q  <= axis_d;
      rdv_q   <= rdv_d;
      cnt_q   <= cnt_d;
    end
  end

  // Hold datapath and result registers
  always_ff @(posedge clk_i) begin
    rd_i_q   <= rd_i_d;
    sum_q    <= sum_d;
    before_q <= before_d;
    ctbs_q   <= ctbs_d;
    s0_q     <= s0_d;
    cols_q   <= cols_d;
    rows_q   <= rows_d;
    col_q    <= col_d;
    row_q    <= row_d;
    over_x_q <= over_x_d;
    top_q    <= top_d;
    left_q   <= left_d;
    width_q  <= width_d;
    height_q <= height_d;
    status_q <= status_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign tile_top_o    = top_q;
  assign tile_left_o   = left_q;
  assign tile_width_o  = width_q;
  assign tile_height_o = height_q;
  assign status_o      = status_q;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while a request is still in work");

  a_range_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_RANGE) |->
      (tile_width_o == '0 && tile_height_o == '0 && tile_top_o == '0))
    else $error("out-of-grid result carries a non-zero region");

  a_axis_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AXIS) |->
      ($past(state_q) == S_GRID || $past(state_q) == S_U_DIV1 ||
       $past(state_q) == S_E_LAST))
    else $error("axis set-up entered from an unexpected step");

endmodule

// ===== bench/tile_region_checker.sv =====
module tile_region_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [1:0]                    kind_i,
  input  logic [trc_pkg::SLOT_W-1:0]     table_slot_i,
  input  logic [trc_pkg::SIZE_W-1:0]     size_in_ctus_minus1_i,
  input  logic [trc_pkg::IDX_W-1:0]      tile_index_i,
  input  logic                          done_i,
  input  logic [trc_pkg::POS_W-1:0]      tile_top_i,
  input  logic [trc_pkg::POS_W-1:0]      tile_left_i,
  input  logic [trc_pkg::LEN_W-1:0]      tile_width_i,
  input  logic [trc_pkg::LEN_W-1:0]      tile_height_i,
  input  logic [1:0]                    status_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [trc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [trc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   pending_count_o
);
  import trc_pkg::*;

  localparam int unsigned      TABLE_DEPTH    = 32;
  localparam logic [PIC_W-1:0] RESET_PIC_W    = 15'd3840;
  localparam logic [PIC_W-1:0] RESET_PIC_H    = 15'd1920;
  localparam logic [2:0]       RESET_CTU_LOG2 = 3'd6;

  typedef struct packed {
    logic [POS_W-1:0] top;
    logic [POS_W-1:0] left;
    logic [LEN_W-1:0] width;
    logic [LEN_W-1:0] height;
    status_e          status;
  } tile_region_t;

  // Shadow copy of the configuration and the size tables
  logic [PIC_W-1:0]  pic_w_q;
  logic [PIC_W-1:0]  pic_h_q;
  logic [2:0]        ctu_log2_q;
  logic              uniform_q;
  logic [SLOT_W-1:0] cols_m1_q;
  logic [SLOT_W-1:0] rows_m1_q;
  logic [SIZE_W-1:0] col_sizes [TABLE_DEPTH];
  logic [SIZE_W-1:0] row_sizes [TABLE_DEPTH];

  tile_region_t expected_regions [$];
  int unsigned  mismatches;

  // Place segment pos of n along one axis; flag explicit sizes that overrun the axis
  function automatic void split_axis(input bit vertical, input int unsigned full, n, pos,
                                     output int unsigned origin, span, output bit over);
    int unsigned sh, ctbs, s0, s1, seg, sum, acc, i;
    sh   = ctu_log2_q;
    sum  = 0;
    acc  = 0;
    over = 1'b0;
    if (uniform_q) begin
      ctbs   = (full + (32'd1 << sh) - 1) >> sh;
      s0     = (pos * ctbs) / n;
      s1     = ((pos + 1) * ctbs) / n;
      origin = s0 << sh;
      span   = (pos + 1 == n) ? full - origin : (s1 - s0) << sh;
    end else begin
      for (i = 0; i + 1 < n; i++) begin
        seg = ((vertical ? row_sizes[i] : col_sizes[i]) + 32'd1) << sh;
        if (i < pos) acc += seg;
        sum += seg;
      end
      over   = sum > full;
      origin = acc;
      if (pos + 1 == n) span = over ? 0 : full - sum;
      else span = ((vertical ? row_sizes[pos] : col_sizes[pos]) + 32'd1) << sh;
    end
  endfunction

  // Work out the region a tile query should return
  function automatic tile_region_t derive_tile_region(input logic [IDX_W-1:0] idx);
    tile_region_t r;
    int unsigned  cols, rows, top, left, wid, hgt;
    bit           over_x, over_y;
    r    = '0;
    cols = cols_m1_q + 32'd1;
    rows = rows_m1_q + 32'd1;
    if (idx >= cols * rows) begin
      r.status = STATUS_RANGE;
    end else begin
      split_axis(1'b0, pic_w_q, cols, idx % cols, left, wid, over_x);
      split_axis(1'b1, pic_h_q, rows, idx / cols, top, hgt, over_y);
      r.top    = (top > POS_MAX) ? POS_MAX : top[POS_W-1:0];
      r.left   = (left > POS_MAX) ? POS_MAX : left[POS_W-1:0];
      r.width  = (wid > LEN_MAX) ? LEN_MAX : wid[LEN_W-1:0];
      r.height = (hgt > LEN_MAX) ? LEN_MAX : hgt[LEN_W-1:0];
      r.status = (over_x || over_y) ? STATUS_OVER : STATUS_OK;
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned want, got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Check results first, then take configuration writes and new requests
  always @(posedge clk_i or negedge rst_ni) begin
    tile_region_t want;
    if (!rst_ni) begin
      pic_w_q    = RESET_PIC_W;
      pic_h_q    = RESET_PIC_H;
      ctu_log2_q = RESET_CTU_LOG2;
      uniform_q  = 1'b1;
      cols_m1_q  = '0;
      rows_m1_q  = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        col_sizes[i] = '0;
        row_sizes[i] = '0;
      end
      expected_regions.delete();
      mismatches = 0;
    end else begin
      if (done_i) begin
        if (expected_regions.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, expected nothing, actual %0d %0d %0d %0d %0d",
                   $time, tile_top_i, tile_left_i, tile_width_i, tile_height_i, status_i);
        end else begin
          want = expected_regions.pop_front();
          compare_field("tile_top", want.top, tile_top_i);
          compare_field("tile_left", want.left, tile_left_i);
          compare_field("tile_width", want.width, tile_width_i);
          compare_field("tile_height", want.height, tile_height_i);
          compare_field("status", want.status, status_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_PIC_W:    pic_w_q    = cfg_data_i[PIC_W-1:0];
          REG_PIC_H:    pic_h_q    = cfg_data_i[PIC_W-1:0];
          REG_CTU_LOG2: ctu_log2_q = cfg_data_i[2:0];
          REG_UNIFORM:  uniform_q  = cfg_data_i[0];
          REG_COLS_M1:  cols_m1_q  = cfg_data_i[SLOT_W-1:0];
          REG_ROWS_M1:  rows_m1_q  = cfg_data_i[SLOT_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        case (kind_i)
          KIND_COL:   col_sizes[table_slot_i] = size_in_ctus_minus1_i;
          KIND_ROW:   row_sizes[table_slot_i] = size_in_ctus_minus1_i;
          KIND_QUERY: expected_regions.insert(expected_regions.size(),
                                              derive_tile_region(tile_index_i));
          default: ;
        endcase
      end
    end
    pending_count_o  <= expected_regions.size();
    mismatch_count_o <= mismatches;
  end

endmodule

// ===== bench/tb_hevc_tile_region_calc_core.sv =====
module tb_hevc_tile_region_calc_core;
  import trc_pkg::*;

  localparam int unsigned ITEM_TARGET   = 1950;
  localparam int unsigned CYCLE_LIMIT   = 3000000;
  localparam int unsigned DRAIN_CYCLES  = 140;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [1:0]  KIND_UNUSED   = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [1:0]            kind;
  logic [SLOT_W-1:0]     table_slot;
  logic [SIZE_W-1:0]     size_in_ctus_minus1;
  logic [IDX_W-1:0]      tile_index;
  logic                  done;
  logic [POS_W-1:0]      tile_top;
  logic [POS_W-1:0]      tile_left;
  logic [LEN_W-1:0]      tile_width;
  logic [LEN_W-1:0]      tile_height;
  logic [1:0]            status;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned mismatches;
  int unsigned pending_results;
  int unsigned requests_sent;
  int unsigned burst_left;
  int unsigned cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  hevc_tile_region_calc_core dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .start_i               (start),
    .busy_o                (busy),
    .kind_i                (kind),
    .table_slot_i          (table_slot),
    .size_in_ctus_minus1_i (size_in_ctus_minus1),
    .tile_index_i          (tile_index),
    .done_o                (done),
    .tile_top_o            (tile_top),
    .tile_left_o           (tile_left),
    .tile_width_o          (tile_width),
    .tile_height_o         (tile_height),
    .status_o              (status),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data)
  );

  tile_region_checker region_check (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .start_i               (start),
    .busy_i                (busy),
    .kind_i                (kind),
    .table_slot_i          (table_slot),
    .size_in_ctus_minus1_i (size_in_ctus_minus1),
    .tile_index_i          (tile_index),
    .done_i                (done),
    .tile_top_i            (tile_top),
    .tile_left_i           (tile_left),
    .tile_width_i          (tile_width),
    .tile_height_i         (tile_height),
    .status_i              (status),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_i           (cfg_ready),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data),
    .mismatch_count_o      (mismatches),
    .pending_count_o       (pending_results)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one request, hold it until taken, then pace the next in bursts
  task automatic issue(input logic [1:0] k, input logic [SLOT_W-1:0] slot,
                       input logic [SIZE_W-1:0] sz, input logic [IDX_W-1:0] idx);
    int unsigned gap;
    start               <= 1'b1;
    kind                <= k;
    table_slot          <= slot;
    size_in_ctus_minus1 <= sz;
    tile_index          <= idx;
    do @(posedge clk); while (busy);
    if (k != KIND_UNUSED) requests_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 12);
    end
  endtask

  // Drop start and wait until no result is outstanding and the core has settled
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hold valid across back-to-back writes; the caller drops it
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_config(input logic [PIC_W-1:0] pw, ph, input logic [2:0] lg,
                              input logic uni, input logic [SLOT_W-1:0] cm1, rm1);
    write_reg(REG_PIC_W, pw);
    write_reg(REG_PIC_H, ph);
    write_reg(REG_CTU_LOG2, CFG_DATA_W'(lg));
    write_reg(REG_UNIFORM, CFG_DATA_W'(uni));
    write_reg(REG_COLS_M1, CFG_DATA_W'(cm1));
    write_reg(REG_ROWS_M1, CFG_DATA_W'(rm1));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [PIC_W-1:0] pick_picture_dim();
    int unsigned r;
    r = $urandom_range(0, 19);
    case (r)
      0:       return '0;
      1:       return PIC_W'(1);
      2:       return PIC_W'(8);
      3:       return PIC_W'(16384);
      4:       return '1;
      default: return PIC_W'($urandom_range(8, 16384));
    endcase
  endfunction

  // Mostly small grids so that tables stay cheap to load
  function automatic logic [SLOT_W-1:0] pick_grid_m1();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return SLOT_W'($urandom_range(0, 3));
    if (r < 8) return SLOT_W'($urandom_range(4, 11));
    return SLOT_W'($urandom_range(12, 31));
  endfunction

  // Load the non-last entries of one axis; fitting sizes keep the sum inside the picture
  task automatic load_axis(input logic [1:0] k, input int unsigned dim, n, lg, input bit fit);
    int unsigned slot, per, cap;
    per = (dim >> lg) / n;
    cap = !fit ? 1023 : (per == 0 ? 0 : (per > 1024 ? 1023 : per - 1));
    for (slot = 0; slot + 1 < n; slot++)
      issue(k, SLOT_W'(slot), SIZE_W'($urandom_range(0, cap)), IDX_W'($urandom()));
  endtask

  // One random setting followed by a mix of queries, table rewrites and junk kinds
  task automatic random_phase();
    logic [PIC_W-1:0]  pw, ph;
    logic [2:0]        lg;
    logic              uni;
    logic [SLOT_W-1:0] cm1, rm1;
    int unsigned       tiles, n_req, pick, j;
    bit                fit;
    pw  = pick_picture_dim();
    ph  = pick_picture_dim();
    lg  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(3, 6));
    uni = 1'($urandom_range(0, 1));
    cm1 = pick_grid_m1();
    rm1 = pick_grid_m1();
    wait_idle();
    apply_config(pw, ph, lg, uni, cm1, rm1);
    tiles = (cm1 + 1) * (rm1 + 1);
    if (!uni) begin
      fit = ($urandom_range(0, 3) != 0);
      load_axis(KIND_COL, pw, cm1 + 1, lg, fit);
      load_axis(KIND_ROW, ph, rm1 + 1, lg, fit);
    end
    n_req = $urandom_range(8, 40);
    for (j = 0; j < n_req; j++) begin
      pick = $urandom_range(0, 99);
      if (pick < 78)
        issue(KIND_QUERY, SLOT_W'($urandom()), SIZE_W'($urandom()),
              IDX_W'($urandom_range(0, tiles - 1)));
      else if (pick < 88)
        issue(KIND_QUERY, SLOT_W'($urandom()), SIZE_W'($urandom()), IDX_W'($urandom()));
      else if (pick < 95)
        issue($urandom_range(0, 1) ? KIND_ROW : KIND_COL, SLOT_W'($urandom()),
              SIZE_W'($urandom()), IDX_W'($urandom()));
      else
        issue(KIND_UNUSED, SLOT_W'($urandom()), SIZE_W'($urandom()), IDX_W'($urandom()));
    end
  endtask

  initial begin
    int unsigned i;
    rst_n               <= 1'b0;
    start               <= 1'b0;
    kind                <= KIND_COL;
    table_slot          <= '0;
    size_in_ctus_minus1 <= '0;
    tile_index          <= '0;
    cfg_valid           <= 1'b0;
    cfg_index           <= REG_PIC_W;
    cfg_data            <= '0;
    requests_sent = 0;
    burst_left    = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting, one tile: the whole picture, then indices outside the grid
    issue(KIND_QUERY, '0, '0, IDX_W'(0));
    issue(KIND_QUERY, '1, '1, IDX_W'(1));
    issue(KIND_QUERY, '0, '0, '1);

    // Widest picture at one-sample CTUs, zero height, full 32 x 32 grid
    wait_idle();
    apply_config('1, '0, 3'd0, 1'b1, '1, '1);
    issue(KIND_QUERY, '0, '0, IDX_W'(0));
    issue(KIND_QUERY, '0, '0, '1);
    issue(KIND_QUERY, '0, '0, IDX_W'(32));

    // Smallest picture, CTU larger than the picture
    wait_idle();
    apply_config(PIC_W'(8), PIC_W'(8), 3'd7, 1'b1, SLOT_W'(2), SLOT_W'(1));
    issue(KIND_QUERY, '0, '0, IDX_W'(0));
    issue(KIND_QUERY, '0, '0, IDX_W'(5));
    issue(KIND_QUERY, '0, '0, IDX_W'(6));

    // Explicit 2 x 2 grid: fitting tables, then a column wider than the picture
    wait_idle();
    apply_config(PIC_W'(1000), PIC_W'(500), 3'd6, 1'b0, SLOT_W'(1), SLOT_W'(1));
    issue(KIND_COL, '0, SIZE_W'(3), IDX_W'($urandom()));
    issue(KIND_ROW, '0, SIZE_W'(1), IDX_W'($urandom()));
    issue(KIND_QUERY, '0, '0, IDX_W'(0));
    issue(KIND_QUERY, '0, '0, IDX_W'(3));
    issue(KIND_COL, '0, '1, IDX_W'($urandom()));
    issue(KIND_QUERY, '0, '0, IDX_W'(1));
    issue(KIND_QUERY, '0, '0, IDX_W'(2));
    issue(KIND_ROW, '1, '1, '1);
    issue(KIND_UNUSED, '1, '1, '1);

    // Fill both tables so that explicit queries never read an unwritten entry
    for (i = 0; i < 32; i++) begin
      issue(KIND_COL, SLOT_W'(i), SIZE_W'($urandom()), IDX_W'($urandom()));
      issue(KIND_ROW, SLOT_W'(i), SIZE_W'($urandom()), IDX_W'($urandom()));
    end

    while (requests_sent < ITEM_TARGET) random_phase();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
